/* rtl/core/pshs_pkg.sv */
package pshs_pkg;

    localparam int KEY_W = 31;
    localparam int CNT_W = 10;
    localparam logic [31:0] HASH_SEED = 32'hdeadbeef;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_ADD   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_NOT_FOUND = 3'd0,
        STAT_FOUND     = 3'd1,
        STAT_INSERTED  = 3'd2,
        STAT_PRESENT   = 3'd3,
        STAT_FULL_DONE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
    } t_cmd;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] left_key;
        logic [KEY_W-1:0] right_key;
    } t_slot;

    function automatic logic [31:0] mix_step(input logic [31:0] t, input logic [31:0] s,
                                             input int k);
        logic [31:0] rot;
        rot = (s << k) | (s >> (32 - k));
        return (t ^ s) - rot;
    endfunction

endpackage

/* rtl/core/pair_hash_set_linear_probe.sv */
// Set of pairs of 31-bit keys held in a hashed table with linear probing.
// Input channel: i_valid, o_stall and i_item (kind, left_key, right_key).
// Kind 0 asks for membership, kind 1 adds the pair, kind 2 clears the set.
// Output channel: o_valid, i_stall and o_result (status, entry_count).
// Every item yields exactly one result, in order.
// A two-entry queue takes items while the table engine is busy.
// A query or add is picked up by the engine, goes through the hash mixing
// steps, reads its home slot and then checks one slot per cycle along the
// probe chain until it finds the pair or an empty slot; the engine stays
// busy until its result is taken. A clear writes every slot, one per cycle,
// and then presents its result.
// After reset the engine empties the table; items are queued meanwhile
// and configuration writes are taken at any time.
// The limit register, written from i_cfg_data, resets to 1023 and is capped at SLOTS - 1.
// While i_stall is high the result holds and the engine waits; the queue
// keeps accepting until it is full.
module pair_hash_set_linear_probe #(
    parameter int SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pshs_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output pshs_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [9:0]          i_cfg_data
);

    logic [9:0]     r_max_entries;
    logic           cmd_valid;
    logic           cmd_ready;
    pshs_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 10'd1023;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_data;
        end
    end

    pshs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    pshs_back #(.SLOTS(SLOTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .i_max_entries (r_max_entries),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result      (o_result)
    );

endmodule

/* rtl/core/pshs_ram.sv */
module pshs_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/pshs_front.sv */
module pshs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  pshs_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output pshs_pkg::t_cmd    o_cmd
);

    pshs_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    pshs_pkg::t_cmd n_cmd;
    logic           push;
    logic           pop;

    always_comb begin
        n_cmd.left_key  = i_item.left_key;
        n_cmd.right_key = i_item.right_key;
        case (i_item.kind)
            pshs_pkg::KIND_QUERY: n_cmd.op = pshs_pkg::OP_QUERY;
            pshs_pkg::KIND_ADD:   n_cmd.op = pshs_pkg::OP_ADD;
            pshs_pkg::KIND_CLEAR: n_cmd.op = pshs_pkg::OP_CLEAR;
            default:              n_cmd.op = pshs_pkg::OP_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && !o_stall;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/core/pshs_back.sv */
module pshs_back #(
    parameter int SLOTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  pshs_pkg::t_cmd       i_cmd,
    input  logic [9:0]           i_max_entries,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pshs_pkg::t_out_item  o_result
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [9:0] CAP = (SLOTS - 1 > 1023) ? 10'd1023 : 10'(SLOTS - 1);
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    pshs_pkg::t_state r_state, n_state;
    pshs_pkg::t_op    r_op, n_op;
    logic [30:0]      r_left, n_left;
    logic [30:0]      r_right, n_right;
    logic [31:0]      r_x, n_x, r_y, n_y, r_z, n_z;
    logic [1:0]       r_step, n_step;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_clr_item, n_clr_item;
    logic [9:0]       r_count, n_count;
    logic [2:0]       r_status, n_status;
    logic [9:0]       limit;

    logic             we;
    logic [AW-1:0]    raddr;
    pshs_pkg::t_slot  wslot;
    pshs_pkg::t_slot  rslot;

    pshs_ram #(.WIDTH($bits(pshs_pkg::t_slot)), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wslot),
        .i_raddr (raddr),
        .o_rdata (rslot)
    );

    assign limit       = (i_max_entries > CAP) ? CAP : i_max_entries;
    assign o_cmd_ready = (r_state == pshs_pkg::ST_IDLE);
    assign o_valid     = (r_state == pshs_pkg::ST_DONE);
    assign o_result    = '{status: r_status, entry_count: r_count};

    always_comb begin
        logic [31:0] t1;
        logic [31:0] t2;
        n_state    = r_state;
        n_op       = r_op;
        n_left     = r_left;
        n_right    = r_right;
        n_x        = r_x;
        n_y        = r_y;
        n_z        = r_z;
        n_step     = r_step;
        n_addr     = r_addr;
        n_clr_item = r_clr_item;
        n_count    = r_count;
        n_status   = r_status;
        we         = 1'b0;
        wslot      = '0;
        raddr      = r_addr;
        t1         = '0;
        t2         = '0;
        case (r_state)
            pshs_pkg::ST_SWEEP: begin
                we = 1'b1;
                if (r_addr == LAST) begin
                    n_count = '0;
                    n_addr  = '0;
                    if (r_clr_item) begin
                        n_status = pshs_pkg::STAT_FULL_DONE;
                        n_state  = pshs_pkg::ST_DONE;
                    end else begin
                        n_state = pshs_pkg::ST_IDLE;
                    end
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            pshs_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_op    = i_cmd.op;
                    n_left  = i_cmd.left_key;
                    n_right = i_cmd.right_key;
                    n_x     = {1'b0, i_cmd.left_key};
                    n_y     = {1'b0, i_cmd.right_key};
                    n_z     = pshs_pkg::HASH_SEED;
                    n_step  = '0;
                    case (i_cmd.op)
                        pshs_pkg::OP_CLEAR: begin
                            n_addr     = '0;
                            n_clr_item = 1'b1;
                            n_state    = pshs_pkg::ST_SWEEP;
                        end
                        pshs_pkg::OP_NOP: begin
                            n_status = pshs_pkg::STAT_NOT_FOUND;
                            n_state  = pshs_pkg::ST_DONE;
                        end
                        default: n_state = pshs_pkg::ST_HASH;
                    endcase
                end
            end
            pshs_pkg::ST_HASH: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    2'd0: begin
                        t1  = pshs_pkg::mix_step(r_z, r_y, 14);
                        n_z = t1;
                        n_x = pshs_pkg::mix_step(r_x, t1, 11);
                    end
                    2'd1: begin
                        t1  = pshs_pkg::mix_step(r_y, r_x, 25);
                        n_y = t1;
                        n_z = pshs_pkg::mix_step(r_z, t1, 16);
                    end
                    2'd2: begin
                        t1  = pshs_pkg::mix_step(r_x, r_z, 4);
                        n_x = t1;
                        n_y = pshs_pkg::mix_step(r_y, t1, 14);
                    end
                    default: begin
                        t2      = pshs_pkg::mix_step(r_z, r_y, 24);
                        n_z     = t2;
                        n_addr  = t2[AW-1:0];
                        n_state = pshs_pkg::ST_READ;
                    end
                endcase
            end
            pshs_pkg::ST_READ: begin
                n_state = pshs_pkg::ST_CHECK;
            end
            pshs_pkg::ST_CHECK: begin
                if (!rslot.used) begin
                    if (r_op == pshs_pkg::OP_ADD) begin
                        if (r_count >= limit) begin
                            n_status = pshs_pkg::STAT_FULL_DONE;
                        end else begin
                            we       = 1'b1;
                            wslot    = '{used: 1'b1, left_key: r_left, right_key: r_right};
                            n_count  = r_count + 1'b1;
                            n_status = pshs_pkg::STAT_INSERTED;
                        end
                    end else begin
                        n_status = pshs_pkg::STAT_NOT_FOUND;
                    end
                    n_state = pshs_pkg::ST_DONE;
                end else if (rslot.left_key == r_left && rslot.right_key == r_right) begin
                    n_status = (r_op == pshs_pkg::OP_ADD) ? pshs_pkg::STAT_PRESENT
                                                          : pshs_pkg::STAT_FOUND;
                    n_state  = pshs_pkg::ST_DONE;
                end else begin
                    n_addr = r_addr + 1'b1;
                    raddr  = r_addr + 1'b1;
                end
            end
            pshs_pkg::ST_DONE: begin
                if (!i_stall) begin
                    n_state = pshs_pkg::ST_IDLE;
                end
            end
            default: n_state = pshs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_left   <= n_left;
        r_right  <= n_right;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_step   <= n_step;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_state    <= pshs_pkg::ST_SWEEP;
            r_addr     <= '0;
            r_clr_item <= 1'b0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_clr_item <= (n_state == pshs_pkg::ST_SWEEP) ? n_clr_item : 1'b0;
            r_count    <= n_count;
        end
    end

endmodule

/* dv/pshs_result_checker.sv */
`timescale 1ns / 1ps

module pshs_result_checker #(
    parameter int SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pshs_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pshs_pkg::t_out_item i_out_result,
    input  logic                i_cfg_we,
    input  logic [9:0]          i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);

    bit                         pair_used [SLOTS];
    logic [pshs_pkg::KEY_W-1:0] pair_left [SLOTS];
    logic [pshs_pkg::KEY_W-1:0] pair_right [SLOTS];
    logic [pshs_pkg::CNT_W-1:0] pair_total;
    logic [pshs_pkg::CNT_W-1:0] pair_limit;
    pshs_pkg::t_out_item        expected_results[$];

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int k);
        return (v << k) | (v >> (32 - k));
    endfunction

    function automatic int home_slot(input logic [pshs_pkg::KEY_W-1:0] a,
                                     input logic [pshs_pkg::KEY_W-1:0] b);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = {1'b0, a};
        y = {1'b0, b};
        z = 32'hdeadbeef;
        z = (z ^ y) - rotate_left(y, 14);
        x = (x ^ z) - rotate_left(z, 11);
        y = (y ^ x) - rotate_left(x, 25);
        z = (z ^ y) - rotate_left(y, 16);
        x = (x ^ z) - rotate_left(z, 4);
        y = (y ^ x) - rotate_left(x, 14);
        z = (z ^ y) - rotate_left(y, 24);
        return int'(z & (SLOTS - 1));
    endfunction

    function automatic pshs_pkg::t_out_item apply_pair_item(input pshs_pkg::t_in_item it);
        pshs_pkg::t_out_item r;
        int        slot;
        int        n;
        bit        hit;
        int        cap;
        r.status = pshs_pkg::STAT_NOT_FOUND;
        hit = 0;
        slot = SLOTS;
        if (it.kind == pshs_pkg::KIND_QUERY || it.kind == pshs_pkg::KIND_ADD) begin
            slot = home_slot(it.left_key, it.right_key);
            for (n = 0; n < SLOTS; n++) begin
                if (!pair_used[slot]) begin
                    break;
                end
                if (pair_left[slot] == it.left_key && pair_right[slot] == it.right_key) begin
                    hit = 1;
                    break;
                end
                slot = (slot + 1) & (SLOTS - 1);
            end
            if (n == SLOTS) begin
                slot = SLOTS;
            end
        end
        cap = (pair_limit > SLOTS - 1) ? SLOTS - 1 : int'(pair_limit);
        case (pshs_pkg::t_kind'(it.kind))
            pshs_pkg::KIND_QUERY: begin
                r.status = hit ? pshs_pkg::STAT_FOUND : pshs_pkg::STAT_NOT_FOUND;
            end
            pshs_pkg::KIND_ADD: begin
                if (hit) begin
                    r.status = pshs_pkg::STAT_PRESENT;
                end else if (pair_total >= cap || slot >= SLOTS) begin
                    r.status = pshs_pkg::STAT_FULL_DONE;
                end else begin
                    pair_used[slot] = 1;
                    pair_left[slot] = it.left_key;
                    pair_right[slot] = it.right_key;
                    pair_total++;
                    r.status = pshs_pkg::STAT_INSERTED;
                end
            end
            pshs_pkg::KIND_CLEAR: begin
                foreach (pair_used[i]) pair_used[i] = 0;
                pair_total = '0;
                r.status = pshs_pkg::STAT_FULL_DONE;
            end
            default: r.status = pshs_pkg::STAT_NOT_FOUND;
        endcase
        r.entry_count = pair_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        pshs_pkg::t_out_item want;
        if (!i_rst_n) begin
            foreach (pair_used[i]) pair_used[i] = 0;
            pair_total = '0;
            pair_limit = 10'd1023;
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                pair_limit = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (o_errors < 10) begin
                        $display("unexpected result: status %0d count %0d",
                                 i_out_result.status, i_out_result.entry_count);
                    end
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_out_result.status
                        || want.entry_count !== i_out_result.entry_count) begin
                        if (o_errors < 10) begin
                            $display("mismatch: expected status %0d count %0d, got %0d %0d",
                                     want.status, want.entry_count,
                                     i_out_result.status, i_out_result.entry_count);
                        end
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_pair_item(i_in_item));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* dv/pair_hash_set_linear_probe_tb.sv */
`timescale 1ns / 1ps

module pair_hash_set_linear_probe_tb;

    localparam int SLOTS = 1024;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [pshs_pkg::KEY_W-1:0] KEY_MAX = '1;

    logic                logic_unused_placeholder_never;
    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_stall;
    pshs_pkg::t_in_item  i_item = '0;
    logic                o_valid;
    logic                i_stall = 0;
    pshs_pkg::t_out_item o_result;
    logic                i_cfg_we = 0;
    logic [9:0]          i_cfg_data = '0;

    int  errors;
    int  pending;
    int  cycle_count = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_token = 0;
    bit  hold_seen = 0;
    int  hold_left = 0;

    assign logic_unused_placeholder_never = 1'b0;

    pair_hash_set_linear_probe #(.SLOTS(SLOTS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    pshs_result_checker #(.SLOTS(SLOTS)) pair_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver counts out a long hold on its own when asked.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= 400;
            i_stall <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input pshs_pkg::t_kind kind,
                             input logic [pshs_pkg::KEY_W-1:0] a,
                             input logic [pshs_pkg::KEY_W-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item <= '{kind: kind, left_key: a, right_key: b};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_and_set_limit(input logic [9:0] limit);
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SLOTS + 20) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_phase(input logic [9:0] limit, input int count, input int pool,
                                input int idle, input int stall, input bit long_hold);
        int  n;
        int  pick;
        logic [pshs_pkg::KEY_W-1:0] a;
        logic [pshs_pkg::KEY_W-1:0] b;
        drain_and_set_limit(limit);
        idle_pct = idle;
        stall_pct = stall;
        for (n = 0; n < count; n++) begin
            if (long_hold && n == 20) begin
                hold_token <= ~hold_token;
            end
            if ($urandom_range(9) == 0) begin
                a = pshs_pkg::KEY_W'($urandom);
                b = pshs_pkg::KEY_W'($urandom);
            end else begin
                a = pshs_pkg::KEY_W'($urandom_range(pool - 1));
                b = pshs_pkg::KEY_W'($urandom_range(pool - 1));
            end
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_item(pshs_pkg::KIND_ADD, a, b);
            end else if (pick < 95) begin
                send_item(pshs_pkg::KIND_QUERY, a, b);
            end else if (pick < 98) begin
                send_item(pshs_pkg::KIND_CLEAR, a, b);
            end else begin
                send_item(pshs_pkg::KIND_NONE, a, b);
            end
        end
    endtask

    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        drain_and_set_limit(10'd1023);
        send_item(pshs_pkg::KIND_QUERY, 0, 0);
        send_item(pshs_pkg::KIND_ADD, 0, 0);
        send_item(pshs_pkg::KIND_ADD, KEY_MAX, KEY_MAX);
        send_item(pshs_pkg::KIND_ADD, 0, KEY_MAX);
        send_item(pshs_pkg::KIND_ADD, KEY_MAX, 0);
        send_item(pshs_pkg::KIND_ADD, 31'h55555555, 31'h2aaaaaaa);
        send_item(pshs_pkg::KIND_QUERY, KEY_MAX, 0);
        send_item(pshs_pkg::KIND_QUERY, 31'h2aaaaaaa, 31'h55555555);
        send_item(pshs_pkg::KIND_ADD, 0, 0);
        send_item(pshs_pkg::KIND_NONE, 0, 0);
        send_item(pshs_pkg::KIND_CLEAR, 0, 0);
        send_item(pshs_pkg::KIND_QUERY, 0, 0);

        drain_and_set_limit(10'd0);
        send_item(pshs_pkg::KIND_ADD, 5, 6);
        send_item(pshs_pkg::KIND_QUERY, 5, 6);

        drain_and_set_limit(10'd1);
        send_item(pshs_pkg::KIND_ADD, 5, 6);
        send_item(pshs_pkg::KIND_ADD, 7, 8);
        send_item(pshs_pkg::KIND_ADD, 5, 6);
        send_item(pshs_pkg::KIND_CLEAR, 0, 0);
        send_item(pshs_pkg::KIND_ADD, 7, 8);

        // Fill the table up to its cap of SLOTS - 1 entries so that the limit applies.
        drain_and_set_limit(10'd1023);
        send_item(pshs_pkg::KIND_CLEAR, 0, 0);
        for (n = 0; n < 1030; n++) begin
            if (n == 100) begin
                hold_token <= ~hold_token;
            end
            send_item(pshs_pkg::KIND_ADD, pshs_pkg::KEY_W'(n), pshs_pkg::KEY_W'($urandom));
        end
        send_item(pshs_pkg::KIND_QUERY, KEY_MAX, 1);
        send_item(pshs_pkg::KIND_ADD, 0, 0);

        random_phase(10'd37, 200, 12, 63, 0, 0);
        random_phase(10'd600, 200, 30, 0, 63, 1);
        random_phase(10'd1, 100, 4, 36, 36, 0);
        random_phase(10'd1023, 300, 20, 0, 0, 0);

        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
